/* sv/per_client_token_bucket_top_defines.svh */
// assertion macros used by the checker file
`ifndef PER_CLIENT_TOKEN_BUCKET_TOP_DEFINES_SVH
`define PER_CLIENT_TOKEN_BUCKET_TOP_DEFINES_SVH

// implication checked in the same cycle
`define PCTB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pctb assertion failed");

// implication checked in the next cycle
`define PCTB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pctb assertion failed");

`endif

/* sv/pctb_pkg.sv */
`timescale 1ns / 1ps

package pctb_pkg;

  // field widths
  localparam int unsigned AddrW    = 32;
  localparam int unsigned TokW     = 36;
  localparam int unsigned MsW      = 32;
  localparam int unsigned RateW    = 30;
  localparam int unsigned BurstW   = 16;
  localparam int unsigned ProdW    = MsW + RateW;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 32;

  // table size default
  localparam int unsigned BucketCount = 16;

  // register reset values and token scale
  localparam logic [RateW-1:0]  RateReset  = RateW'(10000);
  localparam logic [BurstW-1:0] BurstReset = BurstW'(20);
  localparam logic [TokW-1:0]   OneToken   = TokW'(1000000);
  localparam logic [TokW-1:0]   CapReset   = TokW'(20) * OneToken;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgRate  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgBurst = 1'b1;

  // item commands
  localparam logic CmdTick    = 1'b0;
  localparam logic CmdRequest = 1'b1;

  // result status codes
  localparam logic [StatusW-1:0] StAllowed = 2'd0;
  localparam logic [StatusW-1:0] StLimited = 2'd1;
  localparam logic [StatusW-1:0] StFull    = 2'd2;

  typedef struct packed {
    logic             command;
    logic [AddrW-1:0] client_addr;
  } req_t;

  typedef struct packed {
    logic               allowed;
    logic [StatusW-1:0] status;
    logic [TokW-1:0]    tokens_left;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic tick;
    logic capture;
    logic load_idx;
    logic load_elapsed;
    logic load_prod;
    logic load_lvl;
    logic commit_new;
    logic commit_final;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic out_free;
  } ctl_st_t;

endpackage

/* sv/per_client_token_bucket_top.sv */
`timescale 1ns / 1ps

// Per-client token bucket policer. A tick item (command 0) advances the
// millisecond clock and gives no result. A request item looks up its client
// address in a BUCKET_COUNT-entry table and returns one result: a known
// client goes through tag compare, entry select, bucket read, elapsed time,
// 32x30 refill multiply, clamped add, consume and write-back; a new client
// or a full table is answered straight after the tag compare. The block
// takes one item at a time, so a request holds the input stalled until its
// result is written, and longer while the output register holds an untaken
// result. The first request of a new client is always rate limited, and a
// new client with no free entry gets status table full. Configuration writes
// are always ready and must be made while no request is in flight.
module per_client_token_bucket_top #(
  parameter int unsigned BUCKET_COUNT = pctb_pkg::BucketCount
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  pctb_pkg::req_t                in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output pctb_pkg::res_t                out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pctb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pctb_pkg::CfgDataW-1:0] cfg_data_i
);

  pctb_pkg::ctl_cmd_t cmd;
  pctb_pkg::ctl_st_t  st;

  assign cfg_ready_o = 1'b1;

  // sequencer
  pctb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_data_i.command),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // table, refill arithmetic and output register
  pctb_dp #(
    .BUCKET_COUNT (BUCKET_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* sv/pctb_ctrl.sv */
`timescale 1ns / 1ps

module pctb_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_cmd_i,
  output logic               in_stall_o,
  input  pctb_pkg::ctl_st_t  st_i,
  output pctb_pkg::ctl_cmd_t cmd_o
);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SMatch = 3'd1;
  localparam logic [2:0] SRead  = 3'd2;
  localparam logic [2:0] SMul   = 3'd3;
  localparam logic [2:0] SAdd   = 3'd4;
  localparam logic [2:0] SFin   = 3'd5;

  logic [2:0] state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != SIdle);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          if (in_cmd_i == pctb_pkg::CmdRequest) begin
            cmd_o.capture = 1'b1;
            state_d       = SMatch;
          end else begin
            cmd_o.tick = 1'b1;
          end
        end
      end
      SMatch: begin
        if (st_i.hit) begin
          cmd_o.load_idx = 1'b1;
          state_d        = SRead;
        end else if (st_i.out_free) begin
          cmd_o.commit_new = 1'b1;
          state_d          = SIdle;
        end
      end
      SRead: begin
        cmd_o.load_elapsed = 1'b1;
        state_d            = SMul;
      end
      SMul: begin
        cmd_o.load_prod = 1'b1;
        state_d         = SAdd;
      end
      SAdd: begin
        cmd_o.load_lvl = 1'b1;
        state_d        = SFin;
      end
      SFin: begin
        if (st_i.out_free) begin
          cmd_o.commit_final = 1'b1;
          state_d            = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

endmodule

/* sv/pctb_dp.sv */
`timescale 1ns / 1ps

module pctb_dp #(
  parameter int unsigned BUCKET_COUNT = pctb_pkg::BucketCount
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pctb_pkg::req_t                  in_data_i,
  input  logic                            cfg_we_i,
  input  logic [pctb_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [pctb_pkg::CfgDataW-1:0]   cfg_data_i,
  input  pctb_pkg::ctl_cmd_t              cmd_i,
  output pctb_pkg::ctl_st_t               st_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output pctb_pkg::res_t                  out_data_o
);

  localparam int unsigned IdxW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int unsigned TokW = pctb_pkg::TokW;
  localparam int unsigned MsW  = pctb_pkg::MsW;
  localparam int unsigned SumW = pctb_pkg::ProdW + 1;

  // configuration registers
  logic [pctb_pkg::RateW-1:0]  rate_q;
  logic [pctb_pkg::BurstW-1:0] burst_q;
  logic [TokW-1:0]             cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q  <= pctb_pkg::RateReset;
      burst_q <= pctb_pkg::BurstReset;
      cap_q   <= pctb_pkg::CapReset;
    end else begin
      cap_q <= TokW'(burst_q) * pctb_pkg::OneToken;
      if (cfg_we_i) begin
        case (cfg_index_i)
          pctb_pkg::CfgRate:  rate_q  <= cfg_data_i[pctb_pkg::RateW-1:0];
          pctb_pkg::CfgBurst: burst_q <= cfg_data_i[pctb_pkg::BurstW-1:0];
          default: ;
        endcase
      end
    end
  end

  // millisecond clock
  logic [MsW-1:0] now_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q <= '0;
    end else if (cmd_i.tick) begin
      now_q <= now_q + MsW'(1);
    end
  end

  // table tags and valid bits
  logic [BUCKET_COUNT-1:0]      valid_q;
  logic [pctb_pkg::AddrW-1:0]   tag_q [BUCKET_COUNT];
  logic [BUCKET_COUNT-1:0]      hit_vec_q, hit_vec_d;
  logic [BUCKET_COUNT-1:0]      free_vec_q;
  logic [pctb_pkg::AddrW-1:0]   req_addr_q;

  // parallel tag compare on the incoming item
  always_comb begin
    for (int i = 0; i < BUCKET_COUNT; i++) begin
      hit_vec_d[i] = valid_q[i] && (tag_q[i] == in_data_i.client_addr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      hit_vec_q  <= hit_vec_d;
      free_vec_q <= ~valid_q;
      req_addr_q <= in_data_i.client_addr;
    end
  end

  // lowest matching and lowest free entry
  logic [IdxW-1:0] hit_idx, free_idx;

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = BUCKET_COUNT - 1; i >= 0; i--) begin
      if (hit_vec_q[i]) hit_idx = IdxW'(i);
      if (free_vec_q[i]) free_idx = IdxW'(i);
    end
  end

  logic alloc;
  assign alloc = cmd_i.commit_new && (|free_vec_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (alloc) begin
      valid_q[free_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (alloc) begin
      tag_q[free_idx] <= req_addr_q;
    end
  end

  // bucket level and stamp memories
  logic [TokW-1:0] tok_mem   [BUCKET_COUNT];
  logic [MsW-1:0]  stamp_mem [BUCKET_COUNT];
  logic [TokW-1:0] rd_tok_q;
  logic [MsW-1:0]  rd_stamp_q;
  logic [IdxW-1:0] idx_q;
  logic            mem_we;
  logic [IdxW-1:0] wr_idx;
  logic [TokW-1:0] wr_tok;

  always_ff @(posedge clk_i) begin
    rd_tok_q   <= tok_mem[hit_idx];
    rd_stamp_q <= stamp_mem[hit_idx];
    if (mem_we) begin
      tok_mem[wr_idx]   <= wr_tok;
      stamp_mem[wr_idx] <= now_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_idx) begin
      idx_q <= hit_idx;
    end
  end

  // refill pipeline: elapsed, product, clamped sum
  logic [MsW-1:0]             elapsed_q;
  logic                       refill_q;
  logic [TokW-1:0]            lvl_q;
  logic [pctb_pkg::ProdW-1:0] prod_q;
  logic [TokW-1:0]            lvl2_q;
  logic [SumW-1:0]            sum;

  assign sum = {1'b0, prod_q} + SumW'(lvl_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_elapsed) begin
      elapsed_q <= now_q - rd_stamp_q;
      refill_q  <= (now_q != rd_stamp_q);
      lvl_q     <= rd_tok_q;
    end
    if (cmd_i.load_prod) begin
      prod_q <= pctb_pkg::ProdW'(elapsed_q) * pctb_pkg::ProdW'(rate_q);
    end
    if (cmd_i.load_lvl) begin
      if (!refill_q) begin
        lvl2_q <= lvl_q;
      end else if (sum > SumW'(cap_q)) begin
        lvl2_q <= cap_q;
      end else begin
        lvl2_q <= sum[TokW-1:0];
      end
    end
  end

  // token consume
  logic            take;
  logic [TokW-1:0] lvl_final;

  assign take      = (lvl2_q >= pctb_pkg::OneToken);
  assign lvl_final = take ? (lvl2_q - pctb_pkg::OneToken) : lvl2_q;

  assign mem_we = alloc || cmd_i.commit_final;
  assign wr_idx = cmd_i.commit_final ? idx_q : free_idx;
  assign wr_tok = cmd_i.commit_final ? lvl_final : '0;

  // result item and output register
  pctb_pkg::res_t res;
  logic           out_valid_q;
  pctb_pkg::res_t out_q;

  always_comb begin
    res = '0;
    if (cmd_i.commit_final) begin
      res.allowed     = take;
      res.status      = take ? pctb_pkg::StAllowed : pctb_pkg::StLimited;
      res.tokens_left = lvl_final;
    end else if (alloc) begin
      res.status = pctb_pkg::StLimited;
    end else begin
      res.status = pctb_pkg::StFull;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit_new || cmd_i.commit_final) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_new || cmd_i.commit_final) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign st_o.hit      = |hit_vec_q;
  assign st_o.out_free = !out_valid_q || !out_stall_i;

endmodule

/* sv/pctb_checker.sv */
`timescale 1ns / 1ps
`include "per_client_token_bucket_top_defines.svh"

module pctb_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input pctb_pkg::req_t in_data_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input pctb_pkg::res_t out_data_o
);

  logic req_taken;
  logic out_held;
  logic pass_ok;
  logic deny_ok;

  assign req_taken = in_valid_i && !in_stall_o &&
                     (in_data_i.command == pctb_pkg::CmdRequest);
  assign out_held  = out_valid_o && out_stall_i;
  assign pass_ok   = out_data_o.allowed == (out_data_o.status == pctb_pkg::StAllowed);
  assign deny_ok   = out_data_o.allowed ||
                     ((out_data_o.tokens_left < pctb_pkg::OneToken) &&
                      ((out_data_o.status != pctb_pkg::StFull) ||
                       (out_data_o.tokens_left == '0)));

  // a request item keeps the input stalled on the next cycle
  `PCTB_ASSERT_NEXT(a_req_stall, clk_i, rst_ni, req_taken, in_stall_o)

  // a stalled result item stays offered
  `PCTB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o)

  // a stalled result item keeps its payload
  `PCTB_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_held, $stable(out_data_o))

  // pass flag agrees with status
  `PCTB_ASSERT_NOW(a_allowed_status, clk_i, rst_ni, out_valid_o, pass_ok)

  // a rate-limited bucket holds less than one token, a full table reports none
  `PCTB_ASSERT_NOW(a_denied_level, clk_i, rst_ni, out_valid_o, deny_ok)

endmodule

bind per_client_token_bucket_top pctb_checker u_pctb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
